// ----- hw/rtl/bracket_balance_checker_defines.svh -----
// Assertion macros for the bracket balance checker.
// Defining NO_ASSERTIONS turns every use into empty text.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BBC_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bracket balance checker: invariant violated");
`define BBC_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bracket balance checker: next-cycle check failed");
`else
`define BBC_ASSERT_HOLDS(label, clk, rst, prop)
`define BBC_ASSERT_NEXT(label, clk, ante, cons)
`endif

`endif

// ----- hw/rtl/bbc_pkg.sv -----
// Shared types and constants of the bracket balance checker.
// No dependencies; used by bbc_front, bbc_queue, bbc_back and the top level.
`default_nettype none

package bbc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;
   localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;
   localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;
   localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;
   localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;
   localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;

   typedef enum logic [1:0] {
      KIND_ROUND  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_CURLY  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_MISMATCH    = 3'd1,
      ST_EMPTY_CLOSE = 3'd2,
      ST_UNCLOSED    = 3'd3,
      ST_OVERFLOW    = 3'd4
   } status_type;

   typedef struct packed {
      kind_type kind;
      logic     is_open;
      logic     is_close;
      logic     last;
   } item_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bbc_req_if.sv -----
// Character input channel of the bracket balance checker.
// Carries one character and its end-of-string flag per item.
`default_nettype none

interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bbc_rsp_if.sv -----
// Verdict output channel of the bracket balance checker.
// Carries the balanced flag and the status code per item.
`default_nettype none

interface bbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       balanced;
   logic [2:0] status;

   modport source (output valid, output balanced, output status, input ready);
   modport sink (input valid, input balanced, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bbc_front.sv -----
// Front end: accepts characters and classifies them into bracket items.
// Depends on bbc_pkg and bbc_req_if.
`default_nettype none

module bbc_front (
   input  wire logic       clock,
   input  wire logic       reset,
   bbc_req_if.sink         req,
   output logic            item_valid,
   output bbc_pkg::item_type item,
   input  wire logic       item_ready
);

   logic              valid_ff;
   logic              valid_in;
   bbc_pkg::item_type item_ff;
   bbc_pkg::item_type item_in;
   logic              take;

   always_comb begin
      item_in.kind     = bbc_pkg::KIND_ROUND;
      item_in.is_open  = 1'b0;
      item_in.is_close = 1'b0;
      item_in.last     = req.last;
      unique case (req.ch)
         bbc_pkg::CH_ROUND_OPEN: begin
            item_in.is_open = 1'b1;
         end
         bbc_pkg::CH_SQUARE_OPEN: begin
            item_in.kind    = bbc_pkg::KIND_SQUARE;
            item_in.is_open = 1'b1;
         end
         bbc_pkg::CH_CURLY_OPEN: begin
            item_in.kind    = bbc_pkg::KIND_CURLY;
            item_in.is_open = 1'b1;
         end
         bbc_pkg::CH_ROUND_CLOSE: begin
            item_in.is_close = 1'b1;
         end
         bbc_pkg::CH_SQUARE_CLOSE: begin
            item_in.kind     = bbc_pkg::KIND_SQUARE;
            item_in.is_close = 1'b1;
         end
         bbc_pkg::CH_CURLY_CLOSE: begin
            item_in.kind     = bbc_pkg::KIND_CURLY;
            item_in.is_close = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign req.ready = !valid_ff || item_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bbc_queue.sv -----
// Short item queue that decouples the classifier from the stack engine.
// Depends on bbc_pkg.
`default_nettype none

module bbc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire bbc_pkg::item_type in_item,
   output logic                   in_ready,
   output logic                   out_valid,
   output bbc_pkg::item_type      out_item,
   input  wire logic              out_ready
);

   localparam int PTR_W = $clog2(bbc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

   bbc_pkg::item_type slots_ff [bbc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = count_ff != CNT_W'(bbc_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bbc_back.sv -----
// Stack engine: pushes and pops bracket kinds and produces the verdict.
// Depends on bbc_pkg, bbc_rsp_if and bbc_ram.
`default_nettype none

module bbc_back #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire bbc_pkg::item_type item,
   output logic                   item_ready,
   bbc_rsp_if.source              rsp
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);

   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   bbc_pkg::status_type  fail_ff, fail_in;
   bbc_pkg::kind_type    top_ff, top_in;
   logic                 bypass_ff, bypass_in;
   bbc_pkg::kind_type    bypass_kind_ff;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_balanced_ff, out_balanced_in;
   bbc_pkg::status_type  out_status_ff, out_status_in;

   logic                 out_free, fire, push;
   bbc_pkg::kind_type    second;
   bbc_pkg::status_type  verdict;
   logic [DEPTH_W-1:0]   wr_depth, rd_depth;
   logic [1:0]           rd_data;

   // The top entry lives in top_ff; the RAM holds the entries below it.
   bbc_ram #(
      .WIDTH (2),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (push && (depth_ff != '0)),
      .wr_addr (wr_depth[ADDR_W-1:0]),
      .wr_data (top_ff),
      .rd_addr (rd_depth[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign out_free   = !out_valid_ff || rsp.ready;
   assign item_ready = !item.last || out_free;
   assign fire       = item_valid && item_ready;
   assign second     = bypass_ff ? bypass_kind_ff : bbc_pkg::kind_type'(rd_data);
   assign wr_depth   = depth_ff - DEPTH_W'(1);
   assign rd_depth   = depth_in - DEPTH_W'(2);

   always_comb begin
      depth_in = depth_ff;
      fail_in  = fail_ff;
      top_in   = top_ff;
      push     = 1'b0;
      if (fire && (fail_ff == bbc_pkg::ST_OK)) begin
         if (item.is_open) begin
            if (depth_ff == DEPTH_W'(STACK_DEPTH)) begin
               fail_in = bbc_pkg::ST_OVERFLOW;
            end else begin
               push     = 1'b1;
               depth_in = depth_ff + DEPTH_W'(1);
               top_in   = item.kind;
            end
         end else if (item.is_close) begin
            if (depth_ff == '0) begin
               fail_in = bbc_pkg::ST_EMPTY_CLOSE;
            end else begin
               depth_in = depth_ff - DEPTH_W'(1);
               top_in   = second;
               if (top_ff != item.kind) begin
                  fail_in = bbc_pkg::ST_MISMATCH;
               end
            end
         end
      end

      if (fail_in != bbc_pkg::ST_OK) begin
         verdict = fail_in;
      end else if (depth_in != '0) begin
         verdict = bbc_pkg::ST_UNCLOSED;
      end else begin
         verdict = bbc_pkg::ST_OK;
      end

      out_valid_in    = out_valid_ff;
      out_balanced_in = out_balanced_ff;
      out_status_in   = out_status_ff;
      if (fire && item.last) begin
         out_valid_in    = 1'b1;
         out_balanced_in = verdict == bbc_pkg::ST_OK;
         out_status_in   = verdict;
         depth_in        = '0;
         fail_in         = bbc_pkg::ST_OK;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end

      bypass_in = push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         fail_ff      <= bbc_pkg::ST_OK;
         bypass_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         fail_ff      <= fail_in;
         bypass_ff    <= bypass_in;
         out_valid_ff <= out_valid_in;
      end
      top_ff          <= top_in;
      bypass_kind_ff  <= top_ff;
      out_balanced_ff <= out_balanced_in;
      out_status_ff   <= out_status_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.balanced = out_balanced_ff;
   assign rsp.status   = out_status_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bracket_balance_checker.sv -----
// Bracket balance checker: classifier, item queue and stack engine.
// Depends on bbc_pkg, bbc_req_if, bbc_rsp_if, bbc_front, bbc_queue, bbc_back.
//
// Characters arrive one per item on req_bus with last marking the end of a
// string. Round, square and curly brackets are matched on a stack of
// STACK_DEPTH entries; every other byte is ignored. The item with last set
// yields one verdict on rsp_bus: balanced, and a status code (ok, mismatched
// closer, closer on an empty stack, unclosed openers, stack overflow). Other
// items yield nothing. The first failure of a string is the one reported.
// The block takes one character per clock while rsp_bus does not hold it back.
// A verdict passes the classifier register and the queue, after which the
// stack engine, whose push and pop keep the top entry in a register ahead of
// the stack RAM, loads it into its output register.
// While rsp_bus is stalled, characters that are not last keep flowing; the
// queue and the classifier fill only when a last character waits behind an
// untaken verdict.
// Reset empties the stack, the queue and the output register; the stack RAM
// needs no clearing.
`default_nettype none
`include "bracket_balance_checker_defines.svh"

module bracket_balance_checker #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   bbc_req_if.sink   req_bus,
   bbc_rsp_if.source rsp_bus
);

   logic              front_valid, front_ready;
   bbc_pkg::item_type front_item;
   logic              back_valid, back_ready;
   bbc_pkg::item_type back_item;

   bbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .item_valid (front_valid),
      .item       (front_item),
      .item_ready (front_ready)
   );

   bbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .in_ready  (front_ready),
      .out_valid (back_valid),
      .out_item  (back_item),
      .out_ready (back_ready)
   );

   bbc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item       (back_item),
      .item_ready (back_ready),
      .rsp        (rsp_bus)
   );

   `BBC_ASSERT_HOLDS(a_verdict_matches_status, clock, reset, rsp_bus.valid |-> (rsp_bus.balanced == (rsp_bus.status == bbc_pkg::ST_OK)))
   `BBC_ASSERT_HOLDS(a_back_stalls_on_output, clock, reset, !back_ready |-> (rsp_bus.valid && !rsp_bus.ready))
   `BBC_ASSERT_NEXT(a_reset_clears_output, clock, reset, !rsp_bus.valid)

endmodule

`default_nettype wire
